>>> sv/aging_priority_request_queues_macros.svh
// Assertion macros used by the aging priority request queue RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef AGING_PRIORITY_REQUEST_QUEUES_MACROS_SVH
`define AGING_PRIORITY_REQUEST_QUEUES_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define APRQ_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("aprq assertion failed");

// A condition that must hold in the same cycle as its trigger.
`define APRQ_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("aprq assertion failed");

// A condition that must hold in the cycle after its trigger.
`define APRQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("aprq assertion failed");

`else

`define APRQ_ASSERT_ALWAYS(label, expr)
`define APRQ_ASSERT_IMPLY(label, ante, cons)
`define APRQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> sv/aprq_pkg.sv
// Package for the aging priority request queues: field widths, codes,
// controller states and the command/status structs. Depends on nothing.
`timescale 1ns / 1ps

package aprq_pkg;

    // Fixed field widths of the request and result channels.
    localparam int MODE_W     = 2;
    localparam int PRIO_W     = 2;
    localparam int REQ_ID_W   = 16;
    localparam int TS_W       = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Configuration register map (word index taken from paddr[2]).
    localparam logic CFG_IDX_AGING = 1'b0;
    localparam logic [CFG_DATA_W-1:0] AGING_RESET = 32'd1000;

    // Request operations.
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    // Queue selection.
    typedef enum logic [PRIO_W-1:0] {
        PRIO_HIGH   = 2'd0,
        PRIO_MIDDLE = 2'd1,
        PRIO_LOW    = 2'd2,
        PRIO_NONE   = 2'd3
    } t_prio;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_EMPTY     = 2'd3
    } t_status;

    // Kind of result the controller asks the datapath to register.
    typedef enum logic [1:0] {
        RES_OK        = 2'd0,
        RES_FULL      = 2'd1,
        RES_NOT_FOUND = 2'd2,
        RES_PEEK      = 2'd3
    } t_res_kind;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PEEK_RD,
        S_PEEK_CHK,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      capture;   // latch the request, clear index and peek pick
        logic      rd_en;     // read entry memory
        logic      rd_next;   // read at index + 1 instead of index
        logic      wr_push;   // append request at the queue tail
        logic      wr_shift;  // write read data back at index, advance index
        logic      idx_inc;   // advance the scan index
        logic      cnt_dec;   // drop one entry from the selected queue
        logic      peek_upd;  // fold the read head into the peek pick
        logic      res_load;  // load the result register
        t_res_kind res_kind;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_mode mode;
        logic  prio_ok;
        logic  full;
        logic  match;
        logic  scan_end;
        logic  shift_end;
        logic  peek_end;
    } t_dp_sts;

endpackage

>>> sv/aprq_ctrl.sv
// Controller state machine for the aging priority request queues.
// Depends on aprq_pkg; drives aprq_dp through t_dp_cmd and reads t_dp_sts.
`timescale 1ns / 1ps

module aprq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  aprq_pkg::t_dp_sts i_sts,
    output aprq_pkg::t_dp_cmd o_cmd
);
    import aprq_pkg::*;

    t_state    r_state, n_state;
    t_res_kind r_res, n_res;
    logic      r_out_valid, n_out_valid;

    // State, pending result kind and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res       <= RES_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and the result kind decided along the way.
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.mode)
                    MODE_PUSH: begin
                        n_res   = (i_sts.prio_ok && i_sts.full) ? RES_FULL : RES_OK;
                        n_state = S_FINISH;
                    end
                    MODE_DELETE: begin
                        if (i_sts.prio_ok) begin
                            n_state = S_SCAN_RD;
                        end else begin
                            n_res   = RES_OK;
                            n_state = S_FINISH;
                        end
                    end
                    MODE_PEEK: begin
                        n_res   = RES_PEEK;
                        n_state = S_PEEK_RD;
                    end
                    MODE_NONE: begin
                        n_res   = RES_OK;
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SCAN_RD: begin
                if (i_sts.scan_end) begin
                    n_res   = RES_NOT_FOUND;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                n_state = i_sts.match ? S_SHIFT_RD : S_SCAN_RD;
            end
            S_SHIFT_RD: begin
                if (i_sts.shift_end) begin
                    n_res   = RES_OK;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                n_state = S_SHIFT_RD;
            end
            S_PEEK_RD: begin
                n_state = S_PEEK_CHK;
            end
            S_PEEK_CHK: begin
                n_state = i_sts.peek_end ? S_FINISH : S_PEEK_RD;
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath commands and handshake outputs.
    always_comb begin
        o_cmd          = '0;
        o_cmd.res_kind = r_res;
        o_in_stall     = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.wr_push = (i_sts.mode == MODE_PUSH) && i_sts.prio_ok && !i_sts.full;
            end
            S_SCAN_RD: begin
                o_cmd.rd_en = !i_sts.scan_end;
            end
            S_SCAN_CHK: begin
                o_cmd.idx_inc = !i_sts.match;
            end
            S_SHIFT_RD: begin
                o_cmd.cnt_dec = i_sts.shift_end;
                o_cmd.rd_en   = !i_sts.shift_end;
                o_cmd.rd_next = !i_sts.shift_end;
            end
            S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
            end
            S_PEEK_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            S_PEEK_CHK: begin
                o_cmd.peek_upd = 1'b1;
            end
            S_FINISH: begin
                o_cmd.res_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Result valid: set on load, cleared once the result is taken.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.res_load) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> sv/aprq_dp.sv
// Datapath for the aging priority request queues: entry memory, fill
// counts, scan index, peek pick and result register. Depends on aprq_pkg.
`timescale 1ns / 1ps
`include "aging_priority_request_queues_macros.svh"

module aprq_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  aprq_pkg::t_dp_cmd                   i_cmd,
    output aprq_pkg::t_dp_sts                   o_sts,
    input  logic [aprq_pkg::MODE_W-1:0]         i_mode,
    input  logic [aprq_pkg::PRIO_W-1:0]         i_priority_req,
    input  logic [aprq_pkg::REQ_ID_W-1:0]       i_request_id,
    input  logic [aprq_pkg::TS_W-1:0]           i_timestamp,
    input  logic [aprq_pkg::CFG_DATA_W-1:0]     i_aging_threshold,
    output logic [aprq_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_selected_valid,
    output logic [aprq_pkg::REQ_ID_W-1:0]       o_selected_id,
    output logic [aprq_pkg::PRIO_W-1:0]         o_selected_priority
);
    import aprq_pkg::*;

    localparam int AW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int MW        = AW + 2;
    localparam int MEM_DEPTH = 3 * (1 << AW);
    localparam int EW        = ID_BITS + TIME_BITS;
    localparam int XW        = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;

    // Captured request.
    t_mode                r_mode;
    t_prio                r_prio;
    logic [ID_BITS-1:0]   r_id;
    logic [TIME_BITS-1:0] r_ts;

    // Scan index, peek queue and fill counts.
    logic [CW-1:0]        r_idx, n_idx;
    t_prio                r_pq;
    logic [CW-1:0]        r_cnt_h, r_cnt_m, r_cnt_l;
    logic [CW-1:0]        n_cnt_h, n_cnt_m, n_cnt_l;

    // Entry memory, one region per queue, and its read data.
    logic [EW-1:0]        r_mem [MEM_DEPTH];
    logic [EW-1:0]        r_rdata;

    // Peek pick.
    logic                 r_cur_valid;
    logic [ID_BITS-1:0]   r_cur_id;
    logic [TIME_BITS-1:0] r_cur_ts;
    t_prio                r_cur_prio;

    // Result register.
    t_status              r_status;
    logic                 r_sel_valid;
    logic [REQ_ID_W-1:0]  r_sel_id;
    t_prio                r_sel_prio;

    t_prio                q_sel;
    logic [CW-1:0]        cnt_q;
    logic [CW-1:0]        idx_p1;
    logic [CW-1:0]        rd_idx;
    logic [MW-1:0]        raddr;
    logic [MW-1:0]        waddr;
    logic [EW-1:0]        wdata;
    logic                 we;
    logic [ID_BITS-1:0]   head_id;
    logic [TIME_BITS-1:0] head_ts;
    logic [XW-1:0]        ts_gap;
    logic                 aged;
    logic                 take_head;

    // Peek walks the queues in turn; push and delete use their own queue.
    assign q_sel = (r_mode == MODE_PEEK) ? r_pq : r_prio;

    // Fill count of the selected queue.
    always_comb begin
        unique case (q_sel)
            PRIO_HIGH:   cnt_q = r_cnt_h;
            PRIO_MIDDLE: cnt_q = r_cnt_m;
            PRIO_LOW:    cnt_q = r_cnt_l;
            default:     cnt_q = '0;
        endcase
    end

    // Memory addressing: read at index or index + 1, write at tail or index.
    assign idx_p1 = r_idx + CW'(1);
    assign rd_idx = i_cmd.rd_next ? idx_p1 : r_idx;
    assign raddr  = {q_sel, rd_idx[AW-1:0]};
    assign waddr  = i_cmd.wr_push ? {q_sel, cnt_q[AW-1:0]} : {q_sel, r_idx[AW-1:0]};
    assign wdata  = i_cmd.wr_push ? {r_id, r_ts} : r_rdata;
    assign we     = i_cmd.wr_push || i_cmd.wr_shift;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[raddr];
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= t_mode'(i_mode);
            r_prio <= t_prio'(i_priority_req);
            r_id   <= ID_BITS'(i_request_id);
            r_ts   <= TIME_BITS'(i_timestamp);
        end
    end

    // Scan index.
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.capture) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc || i_cmd.wr_shift) begin
            n_idx = idx_p1;
        end
    end

    // Fill counts: push adds one to the selected queue, delete drops one.
    always_comb begin
        n_cnt_h = r_cnt_h;
        n_cnt_m = r_cnt_m;
        n_cnt_l = r_cnt_l;
        if (i_cmd.wr_push || i_cmd.cnt_dec) begin
            unique case (q_sel)
                PRIO_HIGH:   n_cnt_h = i_cmd.wr_push ? r_cnt_h + CW'(1) : r_cnt_h - CW'(1);
                PRIO_MIDDLE: n_cnt_m = i_cmd.wr_push ? r_cnt_m + CW'(1) : r_cnt_m - CW'(1);
                PRIO_LOW:    n_cnt_l = i_cmd.wr_push ? r_cnt_l + CW'(1) : r_cnt_l - CW'(1);
                default:     n_cnt_h = r_cnt_h;
            endcase
        end
    end

    // Aging test of the read head against the current pick.
    assign head_id   = r_rdata[EW-1:TIME_BITS];
    assign head_ts   = r_rdata[TIME_BITS-1:0];
    assign ts_gap    = XW'(r_cur_ts) - XW'(head_ts);
    assign aged      = (r_cur_ts > head_ts) && (ts_gap > XW'(i_aging_threshold));
    assign take_head = (cnt_q != '0) && (!r_cur_valid || aged);

    // Control registers: index, peek queue, counts, peek valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_pq        <= PRIO_HIGH;
            r_cnt_h     <= '0;
            r_cnt_m     <= '0;
            r_cnt_l     <= '0;
            r_cur_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_cnt_h <= n_cnt_h;
            r_cnt_m <= n_cnt_m;
            r_cnt_l <= n_cnt_l;
            if (i_cmd.capture) begin
                r_pq        <= PRIO_HIGH;
                r_cur_valid <= 1'b0;
            end else if (i_cmd.peek_upd) begin
                r_pq <= t_prio'(r_pq + 2'd1);
                if (take_head) begin
                    r_cur_valid <= 1'b1;
                end
            end
        end
    end

    // Peek pick payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.peek_upd && take_head) begin
            r_cur_id   <= head_id;
            r_cur_ts   <= head_ts;
            r_cur_prio <= r_pq;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_sel_valid <= 1'b0;
            r_sel_id    <= '0;
            r_sel_prio  <= PRIO_HIGH;
            unique case (i_cmd.res_kind)
                RES_OK:        r_status <= STAT_OK;
                RES_FULL:      r_status <= STAT_FULL;
                RES_NOT_FOUND: r_status <= STAT_NOT_FOUND;
                RES_PEEK: begin
                    if (r_cur_valid) begin
                        r_status    <= STAT_OK;
                        r_sel_valid <= 1'b1;
                        r_sel_id    <= REQ_ID_W'(r_cur_id);
                        r_sel_prio  <= r_cur_prio;
                    end else begin
                        r_status <= STAT_EMPTY;
                    end
                end
            endcase
        end
    end

    // Status toward the controller.
    always_comb begin
        o_sts           = '0;
        o_sts.mode      = r_mode;
        o_sts.prio_ok   = (r_prio != PRIO_NONE);
        o_sts.full      = (cnt_q >= CW'(QUEUE_DEPTH));
        o_sts.match     = (head_id == r_id);
        o_sts.scan_end  = (r_idx >= cnt_q);
        o_sts.shift_end = (idx_p1 >= cnt_q);
        o_sts.peek_end  = (r_pq == PRIO_LOW);
    end

    assign o_status            = r_status;
    assign o_selected_valid    = r_sel_valid;
    assign o_selected_id       = r_sel_id;
    assign o_selected_priority = r_sel_prio;

    // Checks on counts and memory accesses.
    `APRQ_ASSERT_ALWAYS(a_cnt_h_bound, r_cnt_h <= CW'(QUEUE_DEPTH))
    `APRQ_ASSERT_ALWAYS(a_cnt_m_bound, r_cnt_m <= CW'(QUEUE_DEPTH))
    `APRQ_ASSERT_ALWAYS(a_cnt_l_bound, r_cnt_l <= CW'(QUEUE_DEPTH))
    `APRQ_ASSERT_IMPLY(a_write_queue, we || i_cmd.rd_en, q_sel != PRIO_NONE)
    `APRQ_ASSERT_IMPLY(a_push_room, i_cmd.wr_push, cnt_q < CW'(QUEUE_DEPTH))
    `APRQ_ASSERT_IMPLY(a_shift_inside, i_cmd.wr_shift || i_cmd.cnt_dec, r_idx < cnt_q)

endmodule

>>> sv/aging_priority_request_queues.sv
// Three FIFO request queues (high, middle, low priority) of QUEUE_DEPTH
// entries each, holding a request id and its timestamp. A request is a
// push, a delete or a peek and yields exactly one result. Requests are
// handled one at a time; a result waits in an output register, so the
// next request is taken while it is still unclaimed. The entry memory
// has a single read and a single write port, so a delete reads and
// compares the entries of its queue one at a time and, on a match,
// rewrites each later entry one slot closer to the head. No clearing
// pass runs after reset. aging_threshold sits at byte address 0 of the
// APB port. Depends on aprq_pkg, aprq_ctrl and aprq_dp.
`timescale 1ns / 1ps

module aging_priority_request_queues #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [aprq_pkg::MODE_W-1:0]         i_mode,
    input  logic [aprq_pkg::PRIO_W-1:0]         i_priority_req,
    input  logic [aprq_pkg::REQ_ID_W-1:0]       i_request_id,
    input  logic [aprq_pkg::TS_W-1:0]           i_timestamp,
    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [aprq_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_selected_valid,
    output logic [aprq_pkg::REQ_ID_W-1:0]       o_selected_id,
    output logic [aprq_pkg::PRIO_W-1:0]         o_selected_priority,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aprq_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [aprq_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [aprq_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import aprq_pkg::*;

    logic [CFG_DATA_W-1:0] r_aging_threshold;
    logic                  cfg_write;
    t_dp_cmd               dp_cmd;
    t_dp_sts               dp_sts;

    // Configuration register write and read-back.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aging_threshold <= AGING_RESET;
        end else if (cfg_write && (paddr[2] == CFG_IDX_AGING)) begin
            r_aging_threshold <= pwdata;
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_AGING) ? r_aging_threshold : '0;

    // Sequencer.
    aprq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // Queue storage and result datapath.
    aprq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .o_sts               (dp_sts),
        .i_mode              (i_mode),
        .i_priority_req      (i_priority_req),
        .i_request_id        (i_request_id),
        .i_timestamp         (i_timestamp),
        .i_aging_threshold   (r_aging_threshold),
        .o_status            (o_status),
        .o_selected_valid    (o_selected_valid),
        .o_selected_id       (o_selected_id),
        .o_selected_priority (o_selected_priority)
    );

endmodule

>>> tb/tb_aging_priority_request_queues.sv
// Self-checking testbench for the aging priority request queues.
// Drives requests and the aging threshold register, predicts every result
// from its own copy of the three queues. Needs aprq_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_aging_priority_request_queues;
    import aprq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 50;
    localparam logic [APB_ADDR_W-1:0] AGING_ADDR = {CFG_IDX_AGING, 2'b00};

    // One stored request and one predicted result.
    typedef struct {
        logic [REQ_ID_W-1:0] id;
        logic [TS_W-1:0]     stamp;
    } t_q_entry;

    typedef struct {
        t_status             status;
        logic                sel_valid;
        logic [REQ_ID_W-1:0] sel_id;
        logic [PRIO_W-1:0]   sel_prio;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [MODE_W-1:0]     i_mode;
    logic [PRIO_W-1:0]     i_priority_req;
    logic [REQ_ID_W-1:0]   i_request_id;
    logic [TS_W-1:0]       i_timestamp;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [STATUS_W-1:0]   o_status;
    logic                  o_selected_valid;
    logic [REQ_ID_W-1:0]   o_selected_id;
    logic [PRIO_W-1:0]     o_selected_priority;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state: queue contents and the threshold as last written.
    t_q_entry        held[3][$];
    logic [TS_W-1:0] aging_limit = AGING_RESET;
    t_result         result_due[$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int hold_asked     = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    aging_priority_request_queues uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_mode             (i_mode),
        .i_priority_req     (i_priority_req),
        .i_request_id       (i_request_id),
        .i_timestamp        (i_timestamp),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_selected_valid   (o_selected_valid),
        .o_selected_id      (o_selected_id),
        .o_selected_priority(o_selected_priority),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // Clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #5_000_000;
        $display("aging_priority_request_queues verification failed");
        $finish;
    end

    // True when the other head is older than the current pick by more than the threshold.
    function automatic bit aged_over(logic [TS_W-1:0] cur, logic [TS_W-1:0] other);
        return (cur > other) && ((cur - other) > aging_limit);
    endfunction

    // Applies one accepted request to the queue copy and works out its result.
    task automatic serve_request(input t_mode mode, input t_prio prio,
                                 input logic [REQ_ID_W-1:0] id,
                                 input logic [TS_W-1:0] ts, output t_result r);
        t_q_entry        head;
        bit              have;
        logic [TS_W-1:0] cur;
        int              pos;
        r = '{STAT_OK, 1'b0, '0, '0};
        have = 1'b0;
        cur = '0;
        pos = -1;
        case (mode)
            MODE_PUSH: begin
                if (prio != PRIO_NONE) begin
                    if (held[prio].size() >= QUEUE_DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        head.id    = id;
                        head.stamp = ts;
                        held[prio].insert(held[prio].size(), head);
                    end
                end
            end
            MODE_DELETE: begin
                if (prio != PRIO_NONE) begin
                    foreach (held[prio][i])
                        if (pos < 0 && held[prio][i].id == id)
                            pos = i;
                    if (pos < 0)
                        r.status = STAT_NOT_FOUND;
                    else
                        held[prio].delete(pos);
                end
            end
            MODE_PEEK: begin
                // High head first, then middle and low may take over by aging.
                for (int p = 0; p < 3; p++) begin
                    if (held[p].size() > 0) begin
                        head = held[p][0];
                        if (!have || aged_over(cur, head.stamp)) begin
                            have = 1'b1;
                            cur = head.stamp;
                            r.sel_id = head.id;
                            r.sel_prio = p[PRIO_W-1:0];
                        end
                    end
                end
                if (have)
                    r.sel_valid = 1'b1;
                else
                    r.status = STAT_EMPTY;
            end
            default: ;
        endcase
    endtask

    // Offers one request, waits for it to be taken, then records its expected result.
    task automatic send_request(input t_mode mode, input t_prio prio,
                                input logic [REQ_ID_W-1:0] id, input logic [TS_W-1:0] ts);
        t_result r;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_priority_req <= prio;
        i_request_id   <= id;
        i_timestamp    <= ts;
        do @(posedge i_clk); while (o_in_stall);
        serve_request(mode, prio, id, ts, r);
        result_due.insert(result_due.size(), r);
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic drain_requests();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (result_due.size() != 0)
            @(posedge i_clk);
    endtask

    // APB read of the aging threshold, compared with the predictor's copy.
    task automatic verify_threshold();
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= AGING_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== aging_limit) begin
            $display("%0t: aging_threshold read expected %0h actual %0h",
                     $time, aging_limit, prdata);
            mismatch_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // APB write of the aging threshold, then a read-back check; only called while the block is idle.
    task automatic program_threshold(input logic [CFG_DATA_W-1:0] value);
        drain_requests();
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= AGING_ADDR;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        aging_limit = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        verify_threshold();
    endtask

    // Picks an id that is held in the given queue, or the fallback if it is empty.
    function automatic logic [REQ_ID_W-1:0] choose_held_id(t_prio prio,
                                                           logic [REQ_ID_W-1:0] fallback);
        if (prio == PRIO_NONE || held[prio].size() == 0)
            return fallback;
        return held[prio][$urandom_range(held[prio].size() - 1)].id;
    endfunction

    // Empty queues, ignored codes and a delete that finds nothing.
    task automatic test_empty_and_ignored();
        send_request(MODE_PEEK, PRIO_HIGH, '0, '0);
        send_request(MODE_NONE, PRIO_NONE, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(MODE_PUSH, PRIO_NONE, 16'h1234, 32'd5);
        send_request(MODE_DELETE, PRIO_NONE, 16'h1234, 32'd0);
        send_request(MODE_DELETE, PRIO_HIGH, 16'h0001, 32'd0);
        send_request(MODE_PEEK, PRIO_LOW, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    // Aging boundaries, duplicate ids and the extremes of the threshold.
    task automatic test_aging_rule();
        send_request(MODE_PUSH, PRIO_HIGH, 16'hFFFF, 32'd5000);
        send_request(MODE_PUSH, PRIO_MIDDLE, 16'h0000, 32'd4000);
        send_request(MODE_PEEK, PRIO_HIGH, '0, '0);
        send_request(MODE_PUSH, PRIO_LOW, 16'h0007, 32'd3999);
        send_request(MODE_PEEK, PRIO_HIGH, '0, '0);
        send_request(MODE_PUSH, PRIO_MIDDLE, 16'h0000, 32'd10);
        send_request(MODE_DELETE, PRIO_MIDDLE, 16'h0000, 32'd0);
        send_request(MODE_PEEK, PRIO_HIGH, '0, '0);
        send_request(MODE_DELETE, PRIO_HIGH, 16'hFFFF, 32'd0);
        send_request(MODE_DELETE, PRIO_LOW, 16'h0007, 32'd0);
        send_request(MODE_PEEK, PRIO_HIGH, '0, '0);
        send_request(MODE_DELETE, PRIO_MIDDLE, 16'h0000, 32'd0);
        program_threshold(32'hFFFF_FFFF);
        send_request(MODE_PUSH, PRIO_HIGH, 16'h0001, 32'hFFFF_FFFF);
        send_request(MODE_PUSH, PRIO_LOW, 16'h0002, 32'd0);
        send_request(MODE_PEEK, PRIO_HIGH, '0, '0);
        program_threshold(32'hFFFF_FFFE);
        send_request(MODE_PEEK, PRIO_HIGH, '0, '0);
        program_threshold(32'd0);
        send_request(MODE_PUSH, PRIO_MIDDLE, 16'h0003, 32'hFFFF_FFFF);
        send_request(MODE_PEEK, PRIO_HIGH, '0, '0);
        send_request(MODE_DELETE, PRIO_HIGH, 16'h0001, 32'd0);
        send_request(MODE_DELETE, PRIO_LOW, 16'h0002, 32'd0);
        send_request(MODE_DELETE, PRIO_MIDDLE, 16'h0003, 32'd0);
        send_request(MODE_PEEK, PRIO_HIGH, '0, '0);
    endtask

    // Random traffic in blocks that fill, hold or drain the queues.
    task automatic run_random_traffic(input int n_items, input int unsigned ts_span);
        int                  done;
        int                  block_left;
        int                  push_pct;
        int                  pick;
        t_prio               favored;
        t_mode               mode;
        t_prio               prio;
        logic [REQ_ID_W-1:0] id;
        logic [TS_W-1:0]     ts;
        done = 0;
        block_left = 0;
        push_pct = 50;
        favored = PRIO_HIGH;
        while (done < n_items) begin
            if (block_left == 0) begin
                block_left = 64;
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
                favored = t_prio'($urandom_range(2));
            end
            block_left--;
            prio = ($urandom_range(99) < 50) ? favored : t_prio'($urandom_range(2));
            id = ($urandom_range(99) < 60) ? REQ_ID_W'($urandom_range(15))
                                           : REQ_ID_W'($urandom_range(16'hFFFF));
            ts = ($urandom_range(99) < 80) ? TS_W'($urandom_range(ts_span)) : $urandom;
            pick = $urandom_range(99);
            if ($urandom_range(99) < 4) begin
                // Ignored request: unused mode, or a queue code that names no queue.
                if (pick < 50) begin
                    mode = MODE_NONE;
                    prio = t_prio'($urandom_range(3));
                end else begin
                    mode = (pick < 75) ? MODE_PUSH : MODE_DELETE;
                    prio = PRIO_NONE;
                end
            end else begin
                if (pick < push_pct) begin
                    mode = MODE_PUSH;
                end else if (pick < push_pct + (100 - push_pct) * 3 / 5) begin
                    mode = MODE_DELETE;
                    if ($urandom_range(9) != 0)
                        id = choose_held_id(prio, id);
                end else begin
                    mode = MODE_PEEK;
                end
                done++;
            end
            send_request(mode, prio, id, ts);
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        hold_asked++;
        run_random_traffic(60, 300);
    endtask

    // Receiver stall, with an optional long hold-off counted here.
    always @(negedge i_clk) begin
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compares a single result field and reports a difference.
    function automatic void check_field(string name, longint unsigned due,
                                        longint unsigned got);
        if (due != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, due, got);
            mismatch_count++;
        end
    endfunction

    // Each accepted result is checked against the oldest expected one.
    always @(posedge i_clk) begin
        t_result due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_due.size() == 0) begin
                $display("%0t: unexpected result status %0d id %0h", $time, o_status,
                         o_selected_id);
                mismatch_count++;
            end else begin
                due = result_due[0];
                result_due.delete(0);
                check_field("status", due.status, o_status);
                check_field("selected_valid", due.sel_valid, o_selected_valid);
                check_field("selected_id", due.sel_id, o_selected_id);
                check_field("selected_priority", due.sel_prio, o_selected_priority);
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_mode         = MODE_NONE;
        i_priority_req = PRIO_NONE;
        i_request_id   = '0;
        i_timestamp    = '0;
        i_out_stall    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        verify_threshold();
        test_empty_and_ignored();
        test_aging_rule();

        send_idle_pct = 36;
        stall_pct = 65;
        program_threshold(32'd16);
        run_random_traffic(500, 64);

        send_idle_pct = 65;
        stall_pct = 36;
        program_threshold(32'd1000);
        run_random_traffic(500, 3000);

        send_idle_pct = 0;
        stall_pct = 0;
        program_threshold(32'd0);
        run_random_traffic(400, 8);

        program_threshold($urandom_range(255, 1));
        test_output_backpressure();

        program_threshold(32'hFFFF_FFFF);
        run_random_traffic(200, 32'hFFFF_FFFF);

        program_threshold($urandom_range(255, 1));
        run_random_traffic(200, 512);

        drain_requests();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("aging_priority_request_queues verification clean");
        else
            $display("aging_priority_request_queues verification failed");
        $finish;
    end

endmodule
